FILE: design/bobl_pkg.sv
// shared types and codes for the bounded ordered byte list
`default_nettype none
package bobl_pkg;

	typedef enum logic [2:0] {
		OP_INSERT  = 3'd0,
		OP_APPEND  = 3'd1,
		OP_PREPEND = 3'd2,
		OP_DELETE  = 3'd3,
		OP_POP     = 3'd4
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		DIR_HOLD,
		DIR_OPEN,
		DIR_CLOSE
	} dir_t;

	typedef enum logic [1:0] {
		KEY_ORDER,
		KEY_EQUAL,
		KEY_FREE,
		KEY_ALL
	} key_t;

	typedef struct packed {
		logic               en;
		dir_t               dir;
		key_t               key;
		logic signed [7:0]  value;
	} cell_cmd_t;

endpackage
`default_nettype wire

FILE: design/bobl_cell.sv
// one list cell: holds a byte, finds the first hit and shifts with its neighbors
`default_nettype none
module bobl_cell (
	input  wire logic                clk,
	input  wire bobl_pkg::cell_cmd_t cmd,
	input  wire logic                occ,
	input  wire logic signed [7:0]   left_data,
	input  wire logic signed [7:0]   right_data,
	input  wire logic                found_in,
	output logic                     found_out,
	output logic signed [7:0]        data,
	output logic signed [7:0]        take
);

	logic signed [7:0] data_q;
	logic              hit;
	logic              first;

	always_comb begin
		case (cmd.key)
			bobl_pkg::KEY_ORDER: hit = !occ || !(cmd.value > data_q);
			bobl_pkg::KEY_EQUAL: hit = occ && (data_q == cmd.value);
			bobl_pkg::KEY_FREE:  hit = !occ;
			bobl_pkg::KEY_ALL:   hit = 1'b1;
			default:             hit = 1'b0;
		endcase
	end

	assign found_out = found_in || hit;
	assign first     = hit && !found_in;
	assign data      = data_q;
	assign take      = (cmd.dir == bobl_pkg::DIR_CLOSE && first) ? data_q : 8'sd0;

	always_ff @(posedge clk) begin
		if (cmd.en) begin
			case (cmd.dir)
				bobl_pkg::DIR_OPEN: begin
					if (found_in)
						data_q <= left_data;
					else if (hit)
						data_q <= cmd.value;
				end
				bobl_pkg::DIR_CLOSE: begin
					if (found_out)
						data_q <= right_data;
				end
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: design/bounded_ordered_byte_list_unit.sv
// bounded ordered byte list: top level with control, count and result register
// an accepted request's result is registered straight into the output register
// throughput: one request per cycle while in_stall is low; compare, first-hit ripple and shift all finish
// in that cycle across the row of cells
// reset clears the internal entry count and the result valid; cell contents and the result registers are left as is
`default_nettype none
module bounded_ordered_byte_list_unit #(
	parameter int LIST_DEPTH = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [2:0]        opcode,
	input  wire logic signed [7:0] value,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [1:0]             status,
	output logic signed [7:0]      removed_value,
	output logic [4:0]             entry_count
);

	localparam int CW = $clog2(LIST_DEPTH + 1);

	logic [CW-1:0]             count_q;
	logic [CW-1:0]             count_next;
	logic                      out_valid_q;
	logic [1:0]                status_q;
	logic signed [7:0]         removed_q;
	logic [4:0]                entry_count_q;

	logic                      accept;
	logic                      full;
	logic                      empty;
	bobl_pkg::cell_cmd_t       cmd;
	bobl_pkg::status_t         st;

	logic signed [7:0]         cell_data  [LIST_DEPTH];
	logic signed [7:0]         cell_take  [LIST_DEPTH];
	logic                      found      [LIST_DEPTH+1];
	logic                      occ        [LIST_DEPTH];
	logic signed [7:0]         removed;
	logic [CW+4:0]             count_wide;

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign full     = (count_q == CW'(LIST_DEPTH));
	assign empty    = (count_q == '0);
	assign found[0] = 1'b0;

	always_comb begin
		cmd.en    = accept;
		cmd.dir   = bobl_pkg::DIR_HOLD;
		cmd.key   = bobl_pkg::KEY_ALL;
		cmd.value = value;
		case (opcode)
			bobl_pkg::OP_INSERT, bobl_pkg::OP_APPEND, bobl_pkg::OP_PREPEND: begin
				if (!full) begin
					cmd.dir = bobl_pkg::DIR_OPEN;
					if (opcode == bobl_pkg::OP_INSERT)
						cmd.key = bobl_pkg::KEY_ORDER;
					else if (opcode == bobl_pkg::OP_APPEND)
						cmd.key = bobl_pkg::KEY_FREE;
					else
						cmd.key = bobl_pkg::KEY_ALL;
				end
			end
			bobl_pkg::OP_DELETE: begin
				if (!empty) begin
					cmd.dir = bobl_pkg::DIR_CLOSE;
					cmd.key = bobl_pkg::KEY_EQUAL;
				end
			end
			bobl_pkg::OP_POP: begin
				if (!empty) begin
					cmd.dir = bobl_pkg::DIR_CLOSE;
					cmd.key = bobl_pkg::KEY_ALL;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		st = bobl_pkg::ST_OK;
		case (opcode)
			bobl_pkg::OP_INSERT, bobl_pkg::OP_APPEND, bobl_pkg::OP_PREPEND: begin
				if (full)
					st = bobl_pkg::ST_FULL;
			end
			bobl_pkg::OP_DELETE: begin
				if (empty)
					st = bobl_pkg::ST_EMPTY;
				else if (!found[LIST_DEPTH])
					st = bobl_pkg::ST_NOTFOUND;
			end
			bobl_pkg::OP_POP: begin
				if (empty)
					st = bobl_pkg::ST_EMPTY;
			end
			default: begin
			end
		endcase
	end

	for (genvar gi = 0; gi < LIST_DEPTH; gi++) begin : g_cell
		logic signed [7:0] left_d;
		logic signed [7:0] right_d;

		assign occ[gi] = (count_q > CW'(gi));

		if (gi == 0) begin : g_head
			assign left_d = value;
		end else begin : g_mid_l
			assign left_d = cell_data[gi-1];
		end

		if (gi == LIST_DEPTH - 1) begin : g_tail
			assign right_d = cell_data[gi];
		end else begin : g_mid_r
			assign right_d = cell_data[gi+1];
		end

		bobl_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.occ        (occ[gi]),
			.left_data  (left_d),
			.right_data (right_d),
			.found_in   (found[gi]),
			.found_out  (found[gi+1]),
			.data       (cell_data[gi]),
			.take       (cell_take[gi])
		);
	end

	always_comb begin
		removed = '0;
		for (int i = 0; i < LIST_DEPTH; i++)
			removed = removed | cell_take[i];
	end

	always_comb begin
		count_next = count_q;
		if (cmd.dir == bobl_pkg::DIR_OPEN)
			count_next = count_q + CW'(1);
		else if (cmd.dir == bobl_pkg::DIR_CLOSE && found[LIST_DEPTH])
			count_next = count_q - CW'(1);
	end

	assign count_wide = {5'd0, count_next};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q      <= st;
			removed_q     <= removed;
			entry_count_q <= count_wide[4:0];
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign removed_value = removed_q;
	assign entry_count   = entry_count_q;

endmodule
`default_nettype wire

FILE: tb/tb_bounded_ordered_byte_list_unit.sv
// testbench for bounded_ordered_byte_list_unit: directed table, random requests, predictor check
`timescale 1ns / 1ps
module tb_bounded_ordered_byte_list_unit;

	localparam int LIST_DEPTH = 16;
	localparam logic [2:0] OP_RSVD5 = 3'd5;
	localparam logic [2:0] OP_RSVD6 = 3'd6;
	localparam logic [2:0] OP_RSVD7 = 3'd7;
	localparam int RANDOM_PER_PHASE = 160;

	typedef struct packed {
		bobl_pkg::status_t st;
		logic signed [7:0] removed;
		logic [4:0]        count;
	} list_result_t;

	typedef struct packed {
		logic [2:0]        op;
		logic signed [7:0] val;
		int                reps;
		bit                typed;
		list_result_t      res;
	} plan_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [2:0]        opcode = '0;
	logic signed [7:0] value = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [1:0]        status;
	logic signed [7:0] removed_value;
	logic [4:0]        entry_count;

	logic signed [7:0] held_bytes[$];
	list_result_t      pending_results[$];
	int                mismatches = 0;
	int                send_idle_pct = 0;
	int                recv_stall_pct = 0;
	bit                filling = 1'b1;
	plan_row_t         directed_rows [0:18];

	bounded_ordered_byte_list_unit #(.LIST_DEPTH(LIST_DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.removed_value(removed_value),
		.entry_count(entry_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	function automatic list_result_t apply_request(logic [2:0] op, logic signed [7:0] val);
		list_result_t r;
		int pos;
		r.st = bobl_pkg::ST_OK;
		r.removed = '0;
		pos = 0;
		case (op)
			bobl_pkg::OP_INSERT, bobl_pkg::OP_APPEND, bobl_pkg::OP_PREPEND: begin
				if (held_bytes.size() >= LIST_DEPTH) begin
					r.st = bobl_pkg::ST_FULL;
				end else if (op == bobl_pkg::OP_INSERT) begin
					while (pos < held_bytes.size() && val > held_bytes[pos])
						pos++;
					held_bytes.insert(pos, val);
				end else if (op == bobl_pkg::OP_APPEND) begin
					held_bytes.push_back(val);
				end else begin
					held_bytes.push_front(val);
				end
			end
			bobl_pkg::OP_DELETE: begin
				if (held_bytes.size() == 0) begin
					r.st = bobl_pkg::ST_EMPTY;
				end else begin
					while (pos < held_bytes.size() && held_bytes[pos] != val)
						pos++;
					if (pos < held_bytes.size()) begin
						r.removed = held_bytes[pos];
						held_bytes.delete(pos);
					end else begin
						r.st = bobl_pkg::ST_NOTFOUND;
					end
				end
			end
			bobl_pkg::OP_POP: begin
				if (held_bytes.size() == 0)
					r.st = bobl_pkg::ST_EMPTY;
				else
					r.removed = held_bytes.pop_front();
			end
			default: begin
			end
		endcase
		r.count = 5'(held_bytes.size());
		return r;
	endfunction

	task automatic issue_request(input logic [2:0] op, input logic signed [7:0] val,
			input bit typed, input list_result_t typed_res);
		list_result_t predicted;
		in_valid <= 1'b1;
		opcode <= op;
		value <= val;
		do @(posedge clk); while (in_stall);
		predicted = apply_request(op, val);
		pending_results.push_back(typed ? typed_res : predicted);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic wait_drain();
		while (pending_results.size() != 0) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic pick_random(output logic [2:0] op, output logic signed [7:0] val);
		int r;
		if (held_bytes.size() >= LIST_DEPTH)
			filling = 1'b0;
		else if (held_bytes.size() == 0)
			filling = 1'b1;
		else if ($urandom_range(0, 29) == 0)
			filling = !filling;
		r = $urandom_range(0, 99);
		if ($urandom_range(0, 1) == 0)
			val = 8'($urandom_range(0, 8)) - 8'd4;
		else
			val = 8'($urandom_range(0, 255));
		if (r >= 95) begin
			op = OP_RSVD5 + 3'($urandom_range(0, 2));
		end else if (r < (filling ? 60 : 25)) begin
			case ($urandom_range(0, 2))
				0: op = bobl_pkg::OP_INSERT;
				1: op = bobl_pkg::OP_APPEND;
				default: op = bobl_pkg::OP_PREPEND;
			endcase
		end else if (r < (filling ? 80 : 60)) begin
			op = bobl_pkg::OP_DELETE;
			if (held_bytes.size() != 0 && $urandom_range(0, 9) < 7)
				val = held_bytes[$urandom_range(0, held_bytes.size() - 1)];
		end else begin
			op = bobl_pkg::OP_POP;
		end
	endtask

	always @(posedge clk) begin
		list_result_t exp_res;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result with no request pending");
				mismatches++;
			end else begin
				exp_res = pending_results.pop_front();
				if (status !== exp_res.st) begin
					$error("status expected %0d actual %0d", exp_res.st, status);
					mismatches++;
				end
				if (removed_value !== exp_res.removed) begin
					$error("removed_value expected %0d actual %0d", exp_res.removed,
						removed_value);
					mismatches++;
				end
				if (entry_count !== exp_res.count) begin
					$error("entry_count expected %0d actual %0d", exp_res.count, entry_count);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("tb_bounded_ordered_byte_list_unit: errors");
		$finish;
	end

	initial begin
		logic [2:0]        op;
		logic signed [7:0] val;
		directed_rows = '{
			'{bobl_pkg::OP_POP,     8'sh00, 1,  1'b1, '{bobl_pkg::ST_EMPTY,    8'sh00, 5'd0}},
			'{bobl_pkg::OP_DELETE,  8'sh00, 1,  1'b1, '{bobl_pkg::ST_EMPTY,    8'sh00, 5'd0}},
			'{OP_RSVD5,             8'sh00, 1,  1'b1, '{bobl_pkg::ST_OK,       8'sh00, 5'd0}},
			'{bobl_pkg::OP_INSERT,  8'sh00, 1,  1'b1, '{bobl_pkg::ST_OK,       8'sh00, 5'd1}},
			'{bobl_pkg::OP_INSERT,  8'sh80, 1,  1'b1, '{bobl_pkg::ST_OK,       8'sh00, 5'd2}},
			'{bobl_pkg::OP_INSERT,  8'sh7f, 1,  1'b1, '{bobl_pkg::ST_OK,       8'sh00, 5'd3}},
			'{bobl_pkg::OP_INSERT,  8'sh00, 1,  1'b0, '{bobl_pkg::ST_OK,       8'sh00, 5'd0}},
			'{bobl_pkg::OP_DELETE,  8'sh80, 1,  1'b1, '{bobl_pkg::ST_OK,       8'sh80, 5'd3}},
			'{bobl_pkg::OP_DELETE,  8'sh55, 1,  1'b1, '{bobl_pkg::ST_NOTFOUND, 8'sh00, 5'd3}},
			'{bobl_pkg::OP_APPEND,  8'shaa, 1,  1'b0, '{bobl_pkg::ST_OK,       8'sh00, 5'd0}},
			'{bobl_pkg::OP_PREPEND, 8'sh55, 1,  1'b0, '{bobl_pkg::ST_OK,       8'sh00, 5'd0}},
			'{bobl_pkg::OP_POP,     8'sh00, 1,  1'b0, '{bobl_pkg::ST_OK,       8'sh00, 5'd0}},
			'{bobl_pkg::OP_APPEND,  8'sh01, 12, 1'b0, '{bobl_pkg::ST_OK,       8'sh00, 5'd0}},
			'{bobl_pkg::OP_INSERT,  8'sh00, 1,  1'b1, '{bobl_pkg::ST_FULL,     8'sh00, 5'd16}},
			'{bobl_pkg::OP_APPEND,  8'sh7f, 1,  1'b1, '{bobl_pkg::ST_FULL,     8'sh00, 5'd16}},
			'{bobl_pkg::OP_PREPEND, 8'sh80, 1,  1'b1, '{bobl_pkg::ST_FULL,     8'sh00, 5'd16}},
			'{OP_RSVD7,             8'shff, 1,  1'b1, '{bobl_pkg::ST_OK,       8'sh00, 5'd16}},
			'{bobl_pkg::OP_DELETE,  8'sh7f, 1,  1'b0, '{bobl_pkg::ST_OK,       8'sh00, 5'd0}},
			'{OP_RSVD6,             8'sh00, 1,  1'b0, '{bobl_pkg::ST_OK,       8'sh00, 5'd0}}
		};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 9;
		recv_stall_pct = 88;
		foreach (directed_rows[i])
			repeat (directed_rows[i].reps)
				issue_request(directed_rows[i].op, directed_rows[i].val,
					directed_rows[i].typed, directed_rows[i].res);
		for (int phase = 0; phase < 3; phase++) begin
			wait_drain();
			send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 88 : 0;
			recv_stall_pct = (phase == 0) ? 88 : (phase == 1) ? 9 : 0;
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				pick_random(op, val);
				issue_request(op, val, 1'b0, '0);
				if ($urandom_range(0, 99) == 0)
					wait_drain();
			end
		end
		wait_drain();
		repeat (4) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("tb_bounded_ordered_byte_list_unit: clean");
		else
			$display("tb_bounded_ordered_byte_list_unit: errors");
		$finish;
	end

endmodule
